/* sv/tbit_pkg.sv */
package tbit_pkg;

  // Operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_WR_TB    = 3'd1;
  localparam logic [2:0] OP_RD_TB    = 3'd2;
  localparam logic [2:0] OP_WR_INTVL = 3'd3;
  localparam logic [2:0] OP_RD_INTVL = 3'd4;

  // Fixed widths
  localparam int OP_W     = 3;
  localparam int WORD_W   = 36;
  localparam int RD_LOW_W = 35;
  localparam int TB_W     = 59;
  localparam int PERIOD_W = 24;
  localparam int TTG_W    = 25;

  // Bit where the time base, shifted up by the hidden low bits, splits across the two words
  localparam int WORD_SPLIT = 35;

  typedef struct packed {
    logic [WORD_W-1:0]   read_high;
    logic [RD_LOW_W-1:0] read_low;
    logic                interval_done;
  } result_t;

endpackage

/* sv/time_base_and_interval_timer.sv */
// Machine timer: a 59-bit time base and a 24-bit interval timer with a signed
// time-to-go counter. Every input transfer (tick, time base write/read, interval
// write/read) gives exactly one output transfer. An item passes through the
// input register and then the result register, and a
// new item is taken every cycle as long as the output side keeps draining; the
// state update and result are a single add/compare/shift pass between the two
// registers. Reads return time base bits 58..23 and 22..0 (with the hidden low
// bits as zero), or the interval period shifted up by the hidden low bits.
module time_base_and_interval_timer #(
  parameter int TICK_STEP       = 10000,
  parameter int HIDDEN_LOW_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tbit_pkg::OP_W-1:0]       operation,
  input  logic [tbit_pkg::WORD_W-1:0]     word_high,
  input  logic [tbit_pkg::WORD_W-1:0]     word_low,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tbit_pkg::WORD_W-1:0]     read_high,
  output logic [tbit_pkg::RD_LOW_W-1:0]   read_low,
  output logic                            interval_done
);

  logic                          s1_valid;
  logic [tbit_pkg::OP_W-1:0]     s1_op;
  logic [tbit_pkg::WORD_W-1:0]   s1_high;
  logic [tbit_pkg::WORD_W-1:0]   s1_low;
  logic                          advance;
  tbit_pkg::result_t             res;

  // Stage 1 moves on whenever the result register is free or draining
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  tbit_core #(
    .TICK_STEP       (TICK_STEP),
    .HIDDEN_LOW_BITS (HIDDEN_LOW_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid && advance),
    .operation (s1_op),
    .word_high (s1_high),
    .word_low  (s1_low),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= operation;
      s1_high <= word_high;
      s1_low  <= word_low;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      read_high     <= res.read_high;
      read_low      <= res.read_low;
      interval_done <= res.interval_done;
    end
  end

endmodule

/* sv/tbit_core.sv */
module tbit_core #(
  parameter int TICK_STEP       = 10000,
  parameter int HIDDEN_LOW_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [tbit_pkg::OP_W-1:0]      operation,
  input  logic [tbit_pkg::WORD_W-1:0]    word_high,
  input  logic [tbit_pkg::WORD_W-1:0]    word_low,
  output tbit_pkg::result_t              res
);

  localparam int SHIFT_HI = tbit_pkg::WORD_SPLIT - HIDDEN_LOW_BITS;
  localparam logic [tbit_pkg::TB_W-1:0]  STEP_TB  = tbit_pkg::TB_W'(TICK_STEP);
  localparam logic [tbit_pkg::TTG_W:0]   STEP_TTG = (tbit_pkg::TTG_W + 1)'(TICK_STEP);

  logic [tbit_pkg::TB_W-1:0]     time_base, time_base_next;
  logic [tbit_pkg::PERIOD_W-1:0] interval_period, interval_period_next;
  logic [tbit_pkg::TTG_W-1:0]    time_to_go, time_to_go_next;

  logic [tbit_pkg::TB_W-1:0]     tb_wr;
  logic [tbit_pkg::WORD_W-1:0]   period_shr;
  logic [tbit_pkg::TB_W-1:0]     tb_shr;
  logic [tbit_pkg::TB_W-1:0]     tb_shl;
  logic [tbit_pkg::WORD_W-1:0]   period_shl;
  logic [tbit_pkg::TTG_W:0]      ttg_dec;
  logic                          expired;

  // Word shuffling for the time base and interval accesses
  assign tb_wr = ({{(tbit_pkg::TB_W - tbit_pkg::WORD_W){1'b0}}, word_high} << SHIFT_HI)
               | ({{(tbit_pkg::TB_W - tbit_pkg::RD_LOW_W){1'b0}},
                   word_low[tbit_pkg::RD_LOW_W-1:0]} >> HIDDEN_LOW_BITS);
  assign period_shr = word_high >> HIDDEN_LOW_BITS;
  assign tb_shr     = time_base >> SHIFT_HI;
  assign tb_shl     = time_base << HIDDEN_LOW_BITS;
  assign period_shl = {{(tbit_pkg::WORD_W - tbit_pkg::PERIOD_W){1'b0}}, interval_period}
                      << HIDDEN_LOW_BITS;

  // Signed time-to-go minus the step, one bit wider so it cannot wrap
  assign ttg_dec = {time_to_go[tbit_pkg::TTG_W-1], time_to_go} - STEP_TTG;
  assign expired = ttg_dec[tbit_pkg::TTG_W] || (ttg_dec == '0);

  // Next state and result
  always_comb begin
    time_base_next       = time_base;
    interval_period_next = interval_period;
    time_to_go_next      = time_to_go;
    res                  = '0;
    case (operation)
      tbit_pkg::OP_TICK: begin
        time_base_next = time_base + STEP_TB;
        if (interval_period != '0) begin
          if (expired) begin
            time_to_go_next   = {1'b0, interval_period};
            res.interval_done = 1'b1;
          end else begin
            time_to_go_next = ttg_dec[tbit_pkg::TTG_W-1:0];
          end
        end
      end
      tbit_pkg::OP_WR_TB: begin
        time_base_next = tb_wr;
      end
      tbit_pkg::OP_RD_TB: begin
        res.read_high = tb_shr[tbit_pkg::WORD_W-1:0];
        res.read_low  = tb_shl[tbit_pkg::RD_LOW_W-1:0];
      end
      tbit_pkg::OP_WR_INTVL: begin
        interval_period_next = period_shr[tbit_pkg::PERIOD_W-1:0];
        time_to_go_next      = {1'b0, period_shr[tbit_pkg::PERIOD_W-1:0]};
      end
      tbit_pkg::OP_RD_INTVL: begin
        res.read_high = period_shl;
      end
      default: begin
      end
    endcase
  end

  // Timer state, updated once per item as it retires
  always_ff @(posedge clk) begin
    if (rst) begin
      time_base       <= '0;
      interval_period <= '0;
      time_to_go      <= '0;
    end else if (en) begin
      time_base       <= time_base_next;
      interval_period <= interval_period_next;
      time_to_go      <= time_to_go_next;
    end
  end

endmodule

/* sv/tbit_checker.sv */
module tbit_checker #(
  parameter int HIDDEN_LOW_BITS = 12
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tbit_pkg::WORD_W-1:0]     read_high,
  input logic [tbit_pkg::RD_LOW_W-1:0]   read_low,
  input logic                            interval_done
);

  localparam logic [tbit_pkg::RD_LOW_W-1:0] LOW_MASK =
    (tbit_pkg::RD_LOW_W'(1) << HIDDEN_LOW_BITS) - tbit_pkg::RD_LOW_W'(1);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_high) && $stable(read_low)
      && $stable(interval_done))
    else $error("result changed while stalled");

  // Only a tick can expire the interval, and a tick reads nothing
  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && interval_done |-> read_high == '0 && read_low == '0)
    else $error("interval done with read data");

  // Hidden low bits always read as zero
  a_low_hidden: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_low & LOW_MASK) == '0)
    else $error("hidden low bits nonzero");

  // With an empty result register the input side never stalls
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind time_base_and_interval_timer tbit_checker #(
  .HIDDEN_LOW_BITS (HIDDEN_LOW_BITS)
) u_tbit_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_high     (read_high),
  .read_low      (read_low),
  .interval_done (interval_done)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int TICK_STEP       = 10000;
  localparam int HIDDEN_LOW_BITS = 12;

  // Operation codes the block treats as no-ops
  localparam logic [tbit_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [tbit_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_POINT  = 450;
  localparam int QUIET_POINT  = 800;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [tbit_pkg::OP_W-1:0]           operation;
  logic [tbit_pkg::WORD_W-1:0]         word_high;
  logic [tbit_pkg::WORD_W-1:0]         word_low;
  logic                                out_valid;
  logic                                out_ready;
  logic [tbit_pkg::WORD_W-1:0]         read_high;
  logic [tbit_pkg::RD_LOW_W-1:0]       read_low;
  logic                                interval_done;

  typedef struct {
    logic [tbit_pkg::OP_W-1:0]   op;
    logic [tbit_pkg::WORD_W-1:0] hi;
    logic [tbit_pkg::WORD_W-1:0] lo;
    bit                          typed;
    tbit_pkg::result_t           want;
  } directed_row_t;

  // Timer shadow state
  logic [tbit_pkg::TB_W-1:0]            time_base_shadow;
  logic [tbit_pkg::PERIOD_W-1:0]        period_shadow;
  logic signed [tbit_pkg::TTG_W-1:0]    time_to_go_shadow;

  tbit_pkg::result_t pending_results[$];
  directed_row_t     directed_rows[$];
  int                mismatches;
  bit                quiet_tail;

  time_base_and_interval_timer #(
    .TICK_STEP(TICK_STEP),
    .HIDDEN_LOW_BITS(HIDDEN_LOW_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .word_high(word_high),
    .word_low(word_low),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_high(read_high),
    .read_low(read_low),
    .interval_done(interval_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("** time_base_and_interval_timer: FAILED **");
    $finish;
  end

  // Advance the timer shadow by one transfer and return the result it gives
  function automatic tbit_pkg::result_t timer_step(input logic [tbit_pkg::OP_W-1:0] op,
                                                   input logic [tbit_pkg::WORD_W-1:0] hi,
                                                   input logic [tbit_pkg::WORD_W-1:0] lo);
    tbit_pkg::result_t r;
    logic [63:0]       wide;
    longint            remain;
    r = '0;
    case (op)
      tbit_pkg::OP_TICK: begin
        time_base_shadow = time_base_shadow + tbit_pkg::TB_W'(TICK_STEP);
        if (period_shadow != '0) begin
          remain = longint'(time_to_go_shadow) - TICK_STEP;
          if (remain <= 0) begin
            time_to_go_shadow = {1'b0, period_shadow};
            r.interval_done = 1'b1;
          end else begin
            time_to_go_shadow = remain[tbit_pkg::TTG_W-1:0];
          end
        end
      end
      tbit_pkg::OP_WR_TB: begin
        wide = ({28'b0, hi} << (tbit_pkg::WORD_SPLIT - HIDDEN_LOW_BITS)) |
               ({29'b0, lo[tbit_pkg::RD_LOW_W-1:0]} >> HIDDEN_LOW_BITS);
        time_base_shadow = wide[tbit_pkg::TB_W-1:0];
      end
      tbit_pkg::OP_RD_TB: begin
        wide = {5'b0, time_base_shadow} >> (tbit_pkg::WORD_SPLIT - HIDDEN_LOW_BITS);
        r.read_high = wide[tbit_pkg::WORD_W-1:0];
        wide = {5'b0, time_base_shadow} << HIDDEN_LOW_BITS;
        r.read_low = wide[tbit_pkg::RD_LOW_W-1:0];
      end
      tbit_pkg::OP_WR_INTVL: begin
        wide = {28'b0, hi} >> HIDDEN_LOW_BITS;
        period_shadow = wide[tbit_pkg::PERIOD_W-1:0];
        time_to_go_shadow = {1'b0, wide[tbit_pkg::PERIOD_W-1:0]};
      end
      tbit_pkg::OP_RD_INTVL: begin
        wide = {40'b0, period_shadow} << HIDDEN_LOW_BITS;
        r.read_high = wide[tbit_pkg::WORD_W-1:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [tbit_pkg::WORD_W-1:0] random_word();
    logic [tbit_pkg::WORD_W-1:0] w;
    w[31:0]  = $urandom();
    w[35:32] = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic void add_row(input logic [tbit_pkg::OP_W-1:0] op,
                                  input logic [tbit_pkg::WORD_W-1:0] hi,
                                  input logic [tbit_pkg::WORD_W-1:0] lo, input bit typed,
                                  input logic [tbit_pkg::WORD_W-1:0] rh,
                                  input logic [tbit_pkg::RD_LOW_W-1:0] rl,
                                  input logic done);
    directed_row_t row;
    row.op = op;
    row.hi = hi;
    row.lo = lo;
    row.typed = typed;
    row.want.read_high = rh;
    row.want.read_low = rl;
    row.want.interval_done = done;
    directed_rows.push_back(row);
  endfunction

  // Present one item, record its expected result, wait for the transfer
  task automatic send_item(input logic [tbit_pkg::OP_W-1:0] op,
                           input logic [tbit_pkg::WORD_W-1:0] hi,
                           input logic [tbit_pkg::WORD_W-1:0] lo, input bit typed,
                           input tbit_pkg::result_t want);
    tbit_pkg::result_t predicted;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    word_high <= hi;
    word_low  <= lo;
    predicted = timer_step(op, hi, lo);
    pending_results.push_back(typed ? want : predicted);
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver backpressure in random bursts
  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    tbit_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result hi=%h lo=%h done=%b",
                   $time, read_high, read_low, interval_done);
      end else begin
        want = pending_results.pop_front();
        if (read_high !== want.read_high || read_low !== want.read_low ||
            interval_done !== want.interval_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch expected hi=%h lo=%h done=%b, got hi=%h lo=%h done=%b",
                     $time, want.read_high, want.read_low, want.interval_done,
                     read_high, read_low, interval_done);
        end
      end
    end
  end

  initial begin
    int                            i;
    int                            pick;
    logic [tbit_pkg::OP_W-1:0]     op;
    logic [tbit_pkg::WORD_W-1:0]   hi;
    logic [tbit_pkg::WORD_W-1:0]   lo;
    logic [tbit_pkg::PERIOD_W-1:0] period;
    tbit_pkg::result_t             none;

    none = '0;
    mismatches = 0;
    quiet_tail = 1'b0;
    time_base_shadow = '0;
    period_shadow = '0;
    time_to_go_shadow = '0;
    in_valid  <= 1'b0;
    operation <= tbit_pkg::OP_TICK;
    word_high <= '0;
    word_low  <= '0;

    // Directed: reset values, wraparound, ignored bits, expiry corners
    add_row(tbit_pkg::OP_RD_TB,    '0, '0, 1'b1, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_RD_INTVL, '0, '0, 1'b1, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '1, '1, 1'b1, '0, '0, 1'b0);  // timer disabled: no pulse
    add_row(tbit_pkg::OP_RD_TB,    '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_WR_TB,    '1, '1, 1'b1, '0, '0, 1'b0);  // time base to all ones
    add_row(tbit_pkg::OP_RD_TB,    '0, '0, 1'b1, 36'hF_FFFF_FFFF, 35'h7_FFFF_F000, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b1, '0, '0, 1'b0);  // wraps at 59 bits
    add_row(tbit_pkg::OP_RD_TB,    '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_WR_TB,    '0, 36'h8_0000_0000, 1'b1, '0, '0, 1'b0); // top bit dropped
    add_row(tbit_pkg::OP_RD_TB,    '1, '1, 1'b1, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_WR_INTVL, '1, '1, 1'b1, '0, '0, 1'b0);  // largest period
    add_row(tbit_pkg::OP_RD_INTVL, '0, '0, 1'b1, 36'hF_FFFF_F000, '0, 1'b0);
    add_row(tbit_pkg::OP_WR_INTVL, 36'(TICK_STEP) << HIDDEN_LOW_BITS, '0, 1'b1, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b1, '0, '0, 1'b1);  // expires exactly at zero
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b1, '0, '0, 1'b1);
    add_row(tbit_pkg::OP_WR_INTVL, 36'(2 * TICK_STEP + 1) << HIDDEN_LOW_BITS, '0, 1'b0,
            '0, '0, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_WR_INTVL, 36'h1000, '0, 1'b1, '0, '0, 1'b0); // period below one step
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b1, '0, '0, 1'b1);
    add_row(tbit_pkg::OP_WR_INTVL, 36'hFFF, '1, 1'b1, '0, '0, 1'b0);  // hidden bits only
    add_row(tbit_pkg::OP_TICK,     '0, '0, 1'b1, '0, '0, 1'b0);
    add_row(tbit_pkg::OP_RD_INTVL, '0, '0, 1'b0, '0, '0, 1'b0);
    add_row(OP_SPARE_FIRST, '1, '1, 1'b1, '0, '0, 1'b0);
    add_row(OP_SPARE_LAST,  '1, '1, 1'b1, '0, '0, 1'b0);

    do @(posedge clk); while (rst);

    foreach (directed_rows[k])
      send_item(directed_rows[k].op, directed_rows[k].hi, directed_rows[k].lo,
                directed_rows[k].typed, directed_rows[k].want);

    // Random: mostly ticks against short periods so the interval keeps expiring
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_POINT) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == QUIET_POINT) quiet_tail = 1'b1;
      hi = random_word();
      lo = random_word();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = tbit_pkg::OP_TICK;
      end else if (pick < 55) begin
        op = tbit_pkg::OP_RD_TB;
      end else if (pick < 63) begin
        op = tbit_pkg::OP_WR_TB;
        if ($urandom_range(0, 3) == 0) hi = '1;   // near the top, to wrap
      end else if (pick < 75) begin
        op = tbit_pkg::OP_WR_INTVL;
        pick = $urandom_range(0, 19);
        if (pick < 12)      period = tbit_pkg::PERIOD_W'($urandom_range(1, 6 * TICK_STEP));
        else if (pick < 15) period = '0;
        else                period = tbit_pkg::PERIOD_W'($urandom());
        hi = {period, hi[HIDDEN_LOW_BITS-1:0]};
      end else if (pick < 85) begin
        op = tbit_pkg::OP_RD_INTVL;
      end else if (pick < 90) begin
        op = tbit_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end else begin
        op = tbit_pkg::OP_TICK;
      end
      send_item(op, hi, lo, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** time_base_and_interval_timer: PASSED **");
    else
      $display("** time_base_and_interval_timer: FAILED **");
    $finish;
  end

endmodule
